// ----- sv/ngdp_pkg.sv -----
// Package for the next greater digit permutation block: field widths, constants,
// controller states and the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package ngdp_pkg;

  localparam int DEFAULT_MAX_DIGITS = 10;
  localparam int VALUE_W            = 31;
  localparam int NEXT_W             = 32;
  localparam int DIGIT_W            = 4;
  localparam int ACC_W              = 34;
  localparam int QUOT_W             = 28;
  localparam int PROD_W             = 63;
  localparam int RECIP_SHIFT        = 35;

  localparam logic [31:0]       RECIP_TEN = 32'hCCCC_CCCD;
  localparam logic [ACC_W-1:0]  LIMIT_POS = ACC_W'(64'd2147483647);
  localparam logic [NEXT_W-1:0] NONE_CODE = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_PIVOT,
    ST_PIVRD,
    ST_SUCC,
    ST_BUILD,
    ST_FINISH
  } ngdp_state_t;

  typedef struct packed {
    logic load;
    logic split_step;
    logic set_none;
    logic latch_k;
    logic latch_p;
    logic start_build;
    logic build_step;
    logic out_load;
  } ngdp_cmd_t;

  typedef struct packed {
    logic split_done;
    logic split_full;
    logic few_digits;
    logic pivot_found;
    logic build_last;
    logic out_free;
  } ngdp_status_t;

endpackage

// ----- sv/ngdp_datapath.sv -----
// Datapath of the next greater digit permutation block: digit split, pivot and
// successor search, digit rebuild and output register. Depends on ngdp_pkg.
`timescale 1ns / 1ps

module ngdp_datapath import ngdp_pkg::*; #(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ngdp_cmd_t                cmd,
  output ngdp_status_t             status,
  input  logic [VALUE_W-1:0]       in_value,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [NEXT_W-1:0] out_next_value
);

  localparam int IW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [DIGIT_W-1:0] dig_r [MAX_DIGITS];
  logic [VALUE_W-1:0] rest_r;
  logic [CW-1:0]      cnt_r;
  logic               none_r;
  logic [IW-1:0]      k_r;
  logic [IW-1:0]      j_r;
  logic [DIGIT_W-1:0] p_r;
  logic [IW-1:0]      pos_r;
  logic [ACC_W-1:0]   acc_r;
  logic [NEXT_W-1:0]  next_value_r;
  logic               out_valid_r;

  logic [PROD_W-1:0]  prod;
  logic [QUOT_W-1:0]  quot;
  logic [VALUE_W-1:0] quot_x10;
  logic [DIGIT_W-1:0] rem;
  logic [IW-1:0]      k_pick;
  logic               k_any;
  logic [IW-1:0]      j_pick;
  logic [IW-1:0]      t_idx;
  logic [IW-1:0]      rd_idx;
  logic [DIGIT_W-1:0] rd_data;
  logic [DIGIT_W-1:0] digit_sel;
  logic [ACC_W-1:0]   acc_x10;

  // Division by ten through a reciprocal multiply; exact for every 31-bit value.
  assign prod     = PROD_W'(rest_r) * PROD_W'(RECIP_TEN);
  assign quot     = prod[RECIP_SHIFT +: QUOT_W];
  assign quot_x10 = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
  assign rem      = DIGIT_W'(rest_r - quot_x10);

  // Pivot: lowest position whose digit is smaller than its less significant neighbour.
  always_comb begin
    k_pick = '0;
    k_any  = 1'b0;
    for (int k = MAX_DIGITS - 1; k >= 1; k--) begin
      if ((CW'(k) < cnt_r) && (dig_r[k] < dig_r[k-1])) begin
        k_pick = IW'(k);
        k_any  = 1'b1;
      end
    end
  end

  // Successor: lowest position below the pivot that holds a larger digit.
  always_comb begin
    j_pick = '0;
    for (int j = MAX_DIGITS - 1; j >= 0; j--) begin
      if ((IW'(j) < k_r) && (dig_r[j] > p_r)) begin
        j_pick = IW'(j);
      end
    end
  end

  // During the rebuild the digits come out most significant first. Below the
  // pivot the order is reversed, and the successor's slot carries the old pivot.
  assign t_idx = k_r - IW'(1) - pos_r;

  always_comb begin
    if (cmd.latch_p) begin
      rd_idx = k_r;
    end else if (pos_r > k_r) begin
      rd_idx = pos_r;
    end else if (pos_r == k_r) begin
      rd_idx = j_r;
    end else begin
      rd_idx = t_idx;
    end
  end

  assign rd_data = dig_r[rd_idx];

  always_comb begin
    if ((pos_r < k_r) && (t_idx == j_r)) begin
      digit_sel = p_r;
    end else begin
      digit_sel = rd_data;
    end
  end

  assign acc_x10 = {acc_r[ACC_W-4:0], 3'b000} + {acc_r[ACC_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest_r <= in_value;
      cnt_r  <= '0;
      none_r <= 1'b0;
    end else begin
      if (cmd.split_step) begin
        dig_r[cnt_r[IW-1:0]] <= rem;
        rest_r               <= VALUE_W'(quot);
        cnt_r                <= cnt_r + CW'(1);
      end
      if (cmd.set_none) begin
        none_r <= 1'b1;
      end
    end
    if (cmd.latch_k) begin
      k_r <= k_pick;
    end
    if (cmd.latch_p) begin
      p_r <= rd_data;
    end
    if (cmd.start_build) begin
      j_r   <= j_pick;
      pos_r <= IW'(cnt_r - CW'(1));
      acc_r <= '0;
    end else if (cmd.build_step) begin
      acc_r <= acc_x10 + ACC_W'(digit_sel);
      pos_r <= pos_r - IW'(1);
    end
    if (cmd.out_load) begin
      if (none_r || (acc_r > LIMIT_POS)) begin
        next_value_r <= NONE_CODE;
      end else begin
        next_value_r <= acc_r[NEXT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.split_done  = (rest_r == '0);
  assign status.split_full  = (cnt_r == CW'(MAX_DIGITS));
  assign status.few_digits  = (cnt_r < CW'(2));
  assign status.pivot_found = k_any;
  assign status.build_last  = (pos_r == '0);
  assign status.out_free    = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_next_value = next_value_r;

endmodule

// ----- sv/ngdp_ctrl.sv -----
// Controller of the next greater digit permutation block: sequences the datapath
// through split, search, rebuild and output. Depends on ngdp_pkg.
`timescale 1ns / 1ps

module ngdp_ctrl import ngdp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  ngdp_status_t status,
  output ngdp_cmd_t    cmd
);

  ngdp_state_t state_r;
  ngdp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (status.split_done) begin
          state_nxt = ST_PIVOT;
        end else if (status.split_full) begin
          cmd.set_none = 1'b1;
          state_nxt    = ST_FINISH;
        end else begin
          cmd.split_step = 1'b1;
        end
      end
      ST_PIVOT: begin
        if (status.few_digits || !status.pivot_found) begin
          cmd.set_none = 1'b1;
          state_nxt    = ST_FINISH;
        end else begin
          cmd.latch_k = 1'b1;
          state_nxt   = ST_PIVRD;
        end
      end
      ST_PIVRD: begin
        cmd.latch_p = 1'b1;
        state_nxt   = ST_SUCC;
      end
      ST_SUCC: begin
        cmd.start_build = 1'b1;
        state_nxt       = ST_BUILD;
      end
      ST_BUILD: begin
        cmd.build_step = 1'b1;
        if (status.build_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/next_greater_digit_permutation.sv -----
// Top level of the next greater digit permutation block.
// Instantiates ngdp_ctrl and ngdp_datapath; depends on ngdp_pkg.
`timescale 1ns / 1ps

// For each value transferred in, the block returns exactly one result: the
// smallest integer above it built from the same decimal digits, or -1 when the
// value has fewer than two digits, its digits never fall from right to left,
// it has more than MAX_DIGITS digits, or the permutation exceeds 2147483647.
// One value is in work at a time. The digit split produces one digit per
// cycle through a reciprocal multiply by one tenth, and the rebuild folds
// one digit per cycle into a multiply-by-ten accumulator, with the pivot and
// successor searches between them and the loading of the result after them.
// Values found to have no answer during the split or the pivot search finish
// early. The result sits in an output register, so a new value is taken
// while the previous result still waits to be transferred out.

module next_greater_digit_permutation import ngdp_pkg::*; #(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [VALUE_W-1:0]       in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [NEXT_W-1:0] out_next_value
);

  ngdp_cmd_t    cmd;
  ngdp_status_t status;

  // The controller walks the states and issues one command set per cycle.
  ngdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the digits, the search results, the accumulator and
  // the output register.
  ngdp_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_value       (in_value),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_next_value (out_next_value)
  );

endmodule
